FILE: design/esc_pkg.sv
`timescale 1ns / 1ps
package esc_pkg;

   // pipeline depth, accept to result register
   localparam int NUM_STAGES = 13;

   localparam logic [11:0] YEAR_BASE = 12'd1970;

   localparam logic [31:0] CYCLE_SECONDS = 32'd126230400;
   localparam logic [26:0] YEAR1_START   = 27'd31536000;
   localparam logic [26:0] YEAR2_START   = 27'd63072000;
   localparam logic [26:0] YEAR3_START   = 27'd94694400;
   localparam logic [24:0] DAY_SECONDS   = 25'd86400;
   localparam logic [16:0] HOUR_SECONDS  = 17'd3600;
   localparam logic [11:0] MINUTE_SECONDS = 12'd60;

   // reciprocal estimates: floor(x * recip / 2^shift) is the quotient or one below it
   localparam int CYC_SHIFT  = 32;
   localparam int DAY_SHIFT  = 18;
   localparam int HOUR_SHIFT = 13;
   localparam int MIN_SHIFT  = 10;
   localparam logic [5:0] CYC_RECIP  = 6'((64'd1 << CYC_SHIFT) / 64'd126230400);
   localparam logic [8:0] DAY_RECIP  = 9'((64'd1 << DAY_SHIFT) / 64'd675);
   localparam logic [5:0] HOUR_RECIP = 6'((64'd1 << HOUR_SHIFT) / 64'd225);
   localparam logic [6:0] MIN_RECIP  = 7'((64'd1 << MIN_SHIFT) / 64'd15);

   // first zero-based day of each month
   function automatic logic [8:0] month_start(input logic [3:0] month_idx, input logic leap);
      logic [8:0] base;
      case (month_idx)
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         default: base = 9'd0;
      endcase
      return base + 9'(leap && (month_idx >= 4'd2));
   endfunction

endpackage

FILE: design/esc_req_if.sv
`timescale 1ns / 1ps
interface esc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

FILE: design/esc_rsp_if.sv
`timescale 1ns / 1ps
interface esc_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] year;
   logic [3:0]  month;
   logic [4:0]  day_of_month;
   logic [8:0]  day_of_year;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;

   modport source (output valid, output year, output month, output day_of_month,
                   output day_of_year, output hour, output minute, output second,
                   input ready);
   modport sink   (input valid, input year, input month, input day_of_month,
                   input day_of_year, input hour, input minute, input second,
                   output ready);
endinterface

FILE: design/esc_month_lookup.sv
`timescale 1ns / 1ps
module esc_month_lookup import esc_pkg::*; (
   input  logic [8:0] day_of_year,
   input  logic       leap,
   output logic [3:0] month,
   output logic [4:0] day_of_month
);

   logic [3:0] month_idx;
   logic [8:0] day_offset;

   always_comb begin
      month_idx = 4'd0;
      for (int m = 1; m < 12; m++) begin
         if (day_of_year >= month_start(4'(m), leap)) begin
            month_idx = 4'(m);
         end
      end
      day_offset   = day_of_year - month_start(month_idx, leap);
      month        = month_idx + 4'd1;
      day_of_month = day_offset[4:0] + 5'd1;
   end

endmodule

FILE: design/epoch_seconds_to_calendar_unit.sv
`timescale 1ns / 1ps
// epoch seconds to calendar converter
//
// req_if carries one unsigned 32-bit count of seconds since 1970-01-01 UTC per
// transfer; rsp_if returns year, month, day of month, zero-based day of year,
// hour, minute and second for it. leap years follow the plain four-year rule
// (2100 counts as leap). every input gives exactly one result, in order.
//
// every transfer passes through the 13 register stages, which split the
// constant divisions into a reciprocal estimate, a product and a
// compare-and-correct step each. throughput is one transfer per cycle while
// rsp_if.ready stays high.
//
// reset clears the stage valid bits only; rsp_if.valid is low after reset.
// when the receiver holds rsp_if.ready low the last stage keeps its result,
// and earlier stages keep moving into empty slots, so req_if.ready only drops
// once all 13 stages hold a result.
module epoch_seconds_to_calendar_unit import esc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   esc_req_if.sink  req_if,
   esc_rsp_if.source rsp_if
);

   typedef struct packed {
      logic [31:0] t;
      logic [5:0]  cycles;
      logic [31:0] cyc_prod;
      logic [26:0] cyc_rem;
      logic [11:0] year;
      logic        leap;
      logic [24:0] yr_rem;
      logic [8:0]  yday;
      logic [24:0] day_prod;
      logic [16:0] day_secs;
      logic [3:0]  month;
      logic [4:0]  dom;
      logic [4:0]  hour;
      logic [16:0] hour_prod;
      logic [11:0] min_secs;
      logic [5:0]  minute;
      logic [11:0] min_prod;
      logic [5:0]  second;
   } pipe_type;

   pipe_type                stage_ff [NUM_STAGES];
   pipe_type                stage_in [NUM_STAGES];
   logic [NUM_STAGES-1:0]   valid_ff;
   logic [NUM_STAGES-1:0]   valid_in;
   logic [NUM_STAGES-1:0]   advance;

   // estimate products and differences
   logic [37:0] cyc_est;
   logic [31:0] cyc_diff;
   logic [26:0] day_est;
   logic [24:0] day_diff;
   logic [17:0] hour_est;
   logic [16:0] hour_diff;
   logic [15:0] min_est;
   logic [11:0] min_diff;
   logic [1:0]  year_in_cycle;
   logic [26:0] year_offset;
   logic [3:0]  lookup_month;
   logic [4:0]  lookup_dom;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      advance[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_if.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         advance[k] = !valid_ff[k] || advance[k+1];
      end
   end

   assign req_if.ready = advance[0];

   always_comb begin
      valid_in[0] = req_if.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   esc_month_lookup u_month (
      .day_of_year  (stage_ff[6].yday),
      .leap         (stage_ff[6].leap),
      .month        (lookup_month),
      .day_of_month (lookup_dom)
   );

   always_comb begin
      stage_in[0] = '0;
      for (int k = 1; k < NUM_STAGES; k++) begin
         stage_in[k] = stage_ff[k-1];
      end

      // four-year cycle estimate
      cyc_est = 38'(req_if.epoch_seconds) * 38'(CYC_RECIP);
      stage_in[0].t      = req_if.epoch_seconds;
      stage_in[0].cycles = cyc_est[37:32];

      stage_in[1].cyc_prod = 32'(stage_ff[0].cycles) * CYCLE_SECONDS;

      // cycle correction, estimate is exact or one low
      cyc_diff = stage_ff[1].t - stage_ff[1].cyc_prod;
      if (cyc_diff >= CYCLE_SECONDS) begin
         stage_in[2].cycles  = stage_ff[1].cycles + 6'd1;
         stage_in[2].cyc_rem = 27'(cyc_diff - CYCLE_SECONDS);
      end else begin
         stage_in[2].cyc_rem = 27'(cyc_diff);
      end

      // year within the cycle, third year is leap
      if (stage_ff[2].cyc_rem >= YEAR3_START) begin
         year_in_cycle = 2'd3;
         year_offset   = YEAR3_START;
      end else if (stage_ff[2].cyc_rem >= YEAR2_START) begin
         year_in_cycle = 2'd2;
         year_offset   = YEAR2_START;
      end else if (stage_ff[2].cyc_rem >= YEAR1_START) begin
         year_in_cycle = 2'd1;
         year_offset   = YEAR1_START;
      end else begin
         year_in_cycle = 2'd0;
         year_offset   = '0;
      end
      stage_in[3].leap   = (year_in_cycle == 2'd2);
      stage_in[3].yr_rem = 25'(stage_ff[2].cyc_rem - year_offset);
      stage_in[3].year   = YEAR_BASE + {4'd0, stage_ff[2].cycles, 2'b00}
                           + 12'(year_in_cycle);

      // day estimate, 86400 = 128 * 675
      day_est = 27'(stage_ff[3].yr_rem[24:7]) * 27'(DAY_RECIP);
      stage_in[4].yday = day_est[26:18];

      stage_in[5].day_prod = 25'(stage_ff[4].yday) * DAY_SECONDS;

      day_diff = stage_ff[5].yr_rem - stage_ff[5].day_prod;
      if (day_diff >= DAY_SECONDS) begin
         stage_in[6].yday     = stage_ff[5].yday + 9'd1;
         stage_in[6].day_secs = 17'(day_diff - DAY_SECONDS);
      end else begin
         stage_in[6].day_secs = 17'(day_diff);
      end

      // hour estimate, 3600 = 16 * 225; month lookup alongside
      hour_est = 18'(stage_ff[6].day_secs[16:4]) * 18'(HOUR_RECIP);
      stage_in[7].hour  = hour_est[17:13];
      stage_in[7].month = lookup_month;
      stage_in[7].dom   = lookup_dom;

      stage_in[8].hour_prod = 17'(stage_ff[7].hour) * HOUR_SECONDS;

      hour_diff = stage_ff[8].day_secs - stage_ff[8].hour_prod;
      if (hour_diff >= HOUR_SECONDS) begin
         stage_in[9].hour     = stage_ff[8].hour + 5'd1;
         stage_in[9].min_secs = 12'(hour_diff - HOUR_SECONDS);
      end else begin
         stage_in[9].min_secs = 12'(hour_diff);
      end

      // minute estimate, 60 = 4 * 15
      min_est = 16'(stage_ff[9].min_secs[11:2]) * 16'(MIN_RECIP);
      stage_in[10].minute = min_est[15:10];

      stage_in[11].min_prod = 12'(stage_ff[10].minute) * MINUTE_SECONDS;

      min_diff = stage_ff[11].min_secs - stage_ff[11].min_prod;
      if (min_diff >= MINUTE_SECONDS) begin
         stage_in[12].minute = stage_ff[11].minute + 6'd1;
         stage_in[12].second = 6'(min_diff - MINUTE_SECONDS);
      end else begin
         stage_in[12].second = 6'(min_diff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (advance[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // payload holds while its stage is stalled
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (advance[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign rsp_if.valid        = valid_ff[NUM_STAGES-1];
   assign rsp_if.year         = stage_ff[NUM_STAGES-1].year;
   assign rsp_if.month        = stage_ff[NUM_STAGES-1].month;
   assign rsp_if.day_of_month = stage_ff[NUM_STAGES-1].dom;
   assign rsp_if.day_of_year  = stage_ff[NUM_STAGES-1].yday;
   assign rsp_if.hour         = stage_ff[NUM_STAGES-1].hour;
   assign rsp_if.minute       = stage_ff[NUM_STAGES-1].minute;
   assign rsp_if.second       = stage_ff[NUM_STAGES-1].second;

endmodule

FILE: design/esc_checker.sv
`timescale 1ns / 1ps
module esc_checker import esc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [11:0] rsp_year,
   input logic [3:0]  rsp_month,
   input logic [4:0]  rsp_day_of_month,
   input logic [8:0]  rsp_day_of_year,
   input logic [4:0]  rsp_hour,
   input logic [5:0]  rsp_minute,
   input logic [5:0]  rsp_second
);

   localparam int CountWidth = $clog2(NUM_STAGES + 1);

   logic [CountWidth-1:0] pending_ff;
   logic [CountWidth-1:0] pending_in;
   logic                  req_xfer;
   logic                  rsp_xfer;

   assign req_xfer   = req_valid && req_ready;
   assign rsp_xfer   = rsp_valid && rsp_ready;
   assign pending_in = pending_ff + CountWidth'(req_xfer) - CountWidth'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // no result without an outstanding transfer
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != '0))
      else $error("result shown with nothing outstanding");

   // never more in flight than stages
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      (pending_ff == CountWidth'(NUM_STAGES) && !rsp_xfer) |-> !req_ready)
      else $error("input taken with every stage full");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_year) && $stable(rsp_month)
         && $stable(rsp_day_of_month) && $stable(rsp_day_of_year) && $stable(rsp_hour)
         && $stable(rsp_minute) && $stable(rsp_second)))
      else $error("stalled result changed");

   // fields stay in calendar range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day_of_month >= 5'd1
         && rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59
         && rsp_day_of_year <= 9'd365 && rsp_year >= YEAR_BASE))
      else $error("result field out of range");

   // no result is shown right after reset is released
   a_reset_empty: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind epoch_seconds_to_calendar_unit esc_checker u_esc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_year         (rsp_if.year),
   .rsp_month        (rsp_if.month),
   .rsp_day_of_month (rsp_if.day_of_month),
   .rsp_day_of_year  (rsp_if.day_of_year),
   .rsp_hour         (rsp_if.hour),
   .rsp_minute       (rsp_if.minute),
   .rsp_second       (rsp_if.second)
);

FILE: tb/calendar_checker.sv
`timescale 1ns / 1ps
module calendar_checker (
   input  logic clock,
   input  logic reset,
   esc_req_if   req_mon,
   esc_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   pending_count
);

   localparam int unsigned CYCLE_LEN  = 126230400;
   localparam int unsigned COMMON_LEN = 31536000;
   localparam int unsigned LEAP_LEN   = 31622400;
   localparam int unsigned DAY_LEN    = 86400;
   localparam int unsigned HOUR_LEN   = 3600;
   localparam int unsigned FIRST_YEAR = 1970;
   localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [8:0]  day_of_year;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } calendar_type;

   calendar_type pending_dates[$];

   function automatic calendar_type civil_from_epoch(input logic [31:0] secs);
      int unsigned  span, rest, year_num, yday, tod, days_left, mon, mlen, hr;
      logic         leap;
      calendar_type date;
      span     = secs / CYCLE_LEN;
      rest     = secs - span * CYCLE_LEN;
      year_num = FIRST_YEAR + 4 * span;
      leap     = 1'b0;
      // a later year of the cycle can only follow the one before it
      if (rest >= COMMON_LEN) begin
         year_num++;
         rest -= COMMON_LEN;
      end
      if (rest >= COMMON_LEN) begin
         year_num++;
         rest -= COMMON_LEN;
         leap = 1'b1;
      end
      if (rest >= LEAP_LEN) begin
         year_num++;
         rest -= LEAP_LEN;
         leap = 1'b0;
      end
      yday      = rest / DAY_LEN;
      tod       = rest - yday * DAY_LEN;
      days_left = yday;
      mon       = 0;
      // december takes whatever is left
      while (mon < 11) begin
         mlen = MONTH_LEN[mon];
         if (mon == 1 && leap) mlen = 29;
         if (days_left < mlen) break;
         days_left -= mlen;
         mon++;
      end
      hr                = tod / HOUR_LEN;
      tod               = tod - hr * HOUR_LEN;
      date.year         = 12'(year_num);
      date.month        = 4'(mon + 1);
      date.day_of_month = 5'(days_left + 1);
      date.day_of_year  = 9'(yday);
      date.hour         = 5'(hr);
      date.minute       = 6'(tod / 60);
      date.second       = 6'(tod % 60);
      return date;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   always @(posedge clock) begin
      calendar_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            pending_dates.push_back(civil_from_epoch(req_mon.epoch_seconds));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_dates.size() == 0) begin
               report_mismatch("result transfer with nothing pending", 1, 0);
            end else begin
               want = pending_dates.pop_front();
               if (rsp_mon.year !== want.year)
                  report_mismatch("year", rsp_mon.year, want.year);
               if (rsp_mon.month !== want.month)
                  report_mismatch("month", rsp_mon.month, want.month);
               if (rsp_mon.day_of_month !== want.day_of_month)
                  report_mismatch("day_of_month", rsp_mon.day_of_month, want.day_of_month);
               if (rsp_mon.day_of_year !== want.day_of_year)
                  report_mismatch("day_of_year", rsp_mon.day_of_year, want.day_of_year);
               if (rsp_mon.hour !== want.hour)
                  report_mismatch("hour", rsp_mon.hour, want.hour);
               if (rsp_mon.minute !== want.minute)
                  report_mismatch("minute", rsp_mon.minute, want.minute);
               if (rsp_mon.second !== want.second)
                  report_mismatch("second", rsp_mon.second, want.second);
            end
         end
         pending_count <= pending_dates.size();
      end
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import esc_pkg::NUM_STAGES;

   // quiet cycles before the run is declared hung; far above any long stall
   localparam int QUIET_LIMIT = 4000;
   // long receiver hold-off, well past the pipeline depth so the input stalls
   localparam int HOLD_CYCLES = 80;
   localparam int RANDOM_PER_PHASE = 150;

   localparam logic [31:0] CYCLE_LEN = 32'd126230400;
   localparam logic [31:0] DAY_LEN   = 32'd86400;

   // directed timestamps: range ends, unit rollovers, year and cycle edges,
   // leap days in 1972, 2000 and 2100, alternating bit patterns
   localparam logic [31:0] EDGE_STAMPS [24] = '{
      32'd0,          32'd1,          32'd59,         32'd60,
      32'd3599,       32'd3600,       32'd86399,      32'd86400,
      32'd31535999,   32'd31536000,   32'd63071999,   32'd63072000,
      32'd68169600,   32'd94694399,   32'd94694400,   32'd126230399,
      32'd126230400,  32'd951782400,  32'd4102444800, 32'd4107542400,
      32'd4294967295, 32'h8000_0000,  32'h7FFF_FFFF,  32'hAAAA_AAAA
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   // idle odds in percent, set per phase by the stimulus process
   int send_idle_pct = 37;
   int recv_idle_pct = 86;
   bit hold_request  = 1'b0;

   int mismatch_count;
   int pending_count;
   int quiet_cycles = 0;

   esc_req_if req_chan ();
   esc_rsp_if rsp_chan ();

   epoch_seconds_to_calendar_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   calendar_checker date_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // offer one timestamp and wait for its transfer; valid stays high on return
   // so back-to-back items keep it up without a lower-and-raise in one step
   task automatic send_stamp(input logic [31:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.epoch_seconds <= stamp;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // receiver: random back-pressure, or a long hold-off when asked
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus and verdict
   initial begin
      logic [31:0] stamp;
      logic [31:0] year_off;
      int          phase;
      req_chan.valid         <= 1'b0;
      req_chan.epoch_seconds <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under the first idle mix
      foreach (EDGE_STAMPS[i]) send_stamp(EDGE_STAMPS[i]);

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 37;
               recv_idle_pct = 86;
            end
            1: begin
               send_idle_pct = 86;
               recv_idle_pct = 37;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               // sender keeps streaming while the receiver holds off
               hold_request  = 1'b1;
            end
         endcase
         repeat (RANDOM_PER_PHASE) begin
            case ($urandom_range(3))
               0: stamp = $urandom;
               1: begin
                  // a few seconds around a year, leap day or cycle edge
                  case ($urandom_range(4))
                     0: year_off = 32'd0;
                     1: year_off = 32'd31536000;
                     2: year_off = 32'd63072000;
                     3: year_off = 32'd68169600;
                     default: year_off = 32'd94694400;
                  endcase
                  stamp = 32'($urandom_range(33)) * CYCLE_LEN + year_off
                        + 32'($urandom_range(6)) - 32'd3;
               end
               2: stamp = ($urandom / DAY_LEN) * DAY_LEN + 32'($urandom_range(2)) - 32'd1;
               // the last years of the range, 2100 onward
               default: stamp = 32'd4102444800 + 32'($urandom_range(192522495));
            endcase
            send_stamp(stamp);
         end
      end
      req_chan.valid <= 1'b0;

      // drain, then watch for stray results
      while (pending_count != 0) @(posedge clock);
      repeat (2 * NUM_STAGES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
